### rtl/ncc_pkg.sv
`timescale 1ns / 1ps
// ncc_pkg: shared types and constants for the nearest centroid classifier
// used by ncc_front, ncc_back and the top level, depends on nothing

package ncc_pkg;

   localparam int CFG_BITS = 6;
   localparam int CSR_IDX_BITS = 1;
   localparam int SLOT_BITS = 5;
   localparam int DIM_BITS = 5;
   localparam int IDX_BITS = 5;
   localparam int DIST_BITS = 53;

   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTROIDS_IN_USE = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DIMS_IN_USE = 1'b1;

   typedef struct packed {
      logic is_write;
      logic clear;
      logic emit;
   } op_flags_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ISSUE,
      BK_DRAIN
   } bk_state_type;

endpackage

### rtl/ncc_queue.sv
`timescale 1ns / 1ps
// ncc_queue: two-entry queue between front and back end
// depends on nothing outside this file

module ncc_queue #(
   parameter int WIDTH = 37
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/ncc_front.sv
`timescale 1ns / 1ps
// ncc_front: accepts input transactions, drops out-of-range ones, tags the rest
// depends on ncc_pkg

module ncc_front #(
   parameter int MAX_CENTROIDS = 32,
   parameter int MAX_DIMS = 32,
   parameter int VALUE_BITS = 24,
   parameter int QW = 37
) (
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_command,
   input  logic [ncc_pkg::SLOT_BITS-1:0]       req_centroid_slot,
   input  logic [ncc_pkg::DIM_BITS-1:0]        req_dim_index,
   input  logic signed [VALUE_BITS-1:0]        req_coord_value,
   input  logic [ncc_pkg::CFG_BITS-1:0]        ndims_last,
   input  logic                                q_full,
   output logic                                q_push,
   output logic [QW-1:0]                       q_data
);

   import ncc_pkg::*;

   op_flags_type flags;
   logic         keep;

   assign req_ready = !q_full;

   always_comb begin
      flags.is_write = !req_command;
      flags.clear    = (req_dim_index == '0);
      flags.emit     = (CFG_BITS'(req_dim_index) == ndims_last);
      if (flags.is_write) begin
         keep = (32'(req_centroid_slot) < 32'(MAX_CENTROIDS)) &&
                (32'(req_dim_index) < 32'(MAX_DIMS));
      end else begin
         keep = (CFG_BITS'(req_dim_index) <= ndims_last);
      end
      q_push = req_valid && !q_full && keep;
      q_data = {flags, req_centroid_slot, req_dim_index, req_coord_value};
   end

endmodule

### rtl/ncc_back.sv
`timescale 1ns / 1ps
// ncc_back: centroid store, distance accumulators and nearest search
// depends on ncc_pkg

module ncc_back #(
   parameter int MAX_CENTROIDS = 32,
   parameter int MAX_DIMS = 32,
   parameter int VALUE_BITS = 24,
   parameter int QW = 37
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   input  logic [QW-1:0]                       q_data,
   output logic                                q_pop,
   input  logic [ncc_pkg::CFG_BITS-1:0]        ncent_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ncc_pkg::IDX_BITS-1:0]        rsp_nearest_index,
   output logic [ncc_pkg::DIST_BITS-1:0]       rsp_min_distance
);

   import ncc_pkg::*;

   localparam int DEPTH = MAX_CENTROIDS * MAX_DIMS;
   localparam int AW = $clog2(DEPTH);
   localparam int CIW = $clog2(MAX_CENTROIDS);
   localparam int CMPW = (CIW > CFG_BITS) ? CIW : CFG_BITS;
   localparam int VB = VALUE_BITS;
   localparam int DW = VB + 1;
   localparam int SQW = 2 * VB;
   localparam int SW = ((SQW > DIST_BITS) ? SQW : DIST_BITS) + 1;
   localparam int FW = $bits(op_flags_type);

   // queue head
   op_flags_type          q_flags;
   logic [SLOT_BITS-1:0]  q_slot;
   logic [DIM_BITS-1:0]   q_dim;
   logic [VB-1:0]         q_value;

   assign q_flags = op_flags_type'(q_data[QW-1 -: FW]);
   assign q_slot  = q_data[DIM_BITS+VB +: SLOT_BITS];
   assign q_dim   = q_data[VB +: DIM_BITS];
   assign q_value = q_data[VB-1:0];

   // control
   bk_state_type   state_ff;
   bk_state_type   state_in;
   logic [CIW-1:0] c_ff;
   logic [CIW-1:0] c_in;
   logic           start;
   logic           st_we;
   logic           issue;
   logic           c_last;

   // current element
   logic [DIM_BITS-1:0] op_dim_ff;
   logic [VB-1:0]       op_value_ff;
   logic                op_emit_ff;

   // storage
   logic [VB-1:0]        store_mem_ff [DEPTH];
   logic [DIST_BITS-1:0] acc_mem_ff [MAX_CENTROIDS];
   logic [MAX_CENTROIDS-1:0] acc_vld_ff;
   logic [VB-1:0]        store_rd_ff;
   logic [DIST_BITS-1:0] acc_rd_ff;
   logic [AW-1:0]        wr_addr;
   logic [AW-1:0]        rd_addr;

   // pipeline
   logic                 p1_vld_ff;
   logic                 p1_last_ff;
   logic [CIW-1:0]       p1_c_ff;
   logic                 p2_vld_ff;
   logic                 p2_last_ff;
   logic [CIW-1:0]       p2_c_ff;
   logic [VB-1:0]        p2_mag_ff;
   logic [DIST_BITS-1:0] p2_old_ff;
   logic                 p3_vld_ff;
   logic                 p3_last_ff;
   logic [CIW-1:0]       p3_c_ff;
   logic [SQW-1:0]       p3_sq_ff;
   logic [DIST_BITS-1:0] p3_old_ff;

   logic [DW-1:0]        diff;
   logic [DW-1:0]        diff_neg;
   logic [VB-1:0]        mag;
   logic [DIST_BITS-1:0] old_val;
   logic [SW-1:0]        sum;
   logic [DIST_BITS-1:0] sum_sat;
   logic                 take;
   logic [DIST_BITS-1:0] nb_dist;
   logic [CIW-1:0]       nb_idx;

   logic [DIST_BITS-1:0] best_dist_ff;
   logic [CIW-1:0]       best_idx_ff;

   logic                 rsp_valid_ff;
   logic [IDX_BITS-1:0]  rsp_index_ff;
   logic [DIST_BITS-1:0] rsp_dist_ff;

   assign c_last  = (CMPW'(c_ff) == CMPW'(ncent_last));
   assign wr_addr = AW'(q_slot) * AW'(MAX_DIMS) + AW'(q_dim);
   assign rd_addr = AW'(c_ff) * AW'(MAX_DIMS) + AW'(op_dim_ff);

   always_comb begin
      state_in = state_ff;
      c_in     = c_ff;
      q_pop    = 1'b0;
      start    = 1'b0;
      st_we    = 1'b0;
      issue    = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               if (q_flags.is_write) begin
                  q_pop = 1'b1;
                  st_we = 1'b1;
               end else if (!q_flags.emit || !rsp_valid_ff) begin
                  q_pop    = 1'b1;
                  start    = 1'b1;
                  c_in     = '0;
                  state_in = BK_ISSUE;
               end
            end
         end
         BK_ISSUE: begin
            issue = 1'b1;
            if (c_last) begin
               state_in = BK_DRAIN;
            end else begin
               c_in = c_ff + 1'b1;
            end
         end
         BK_DRAIN: begin
            if (p3_vld_ff && p3_last_ff) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in;
      if (start) begin
         op_dim_ff   <= q_dim;
         op_value_ff <= q_value;
         op_emit_ff  <= q_flags.emit;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem_ff[wr_addr] <= q_value;
      end
      if (issue) begin
         store_rd_ff <= store_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (p3_vld_ff) begin
         acc_mem_ff[p3_c_ff] <= sum_sat;
      end
      if (issue) begin
         acc_rd_ff <= acc_mem_ff[c_ff];
      end
   end

   // an invalid accumulator reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_vld_ff <= '0;
      end else if (start && q_flags.clear) begin
         acc_vld_ff <= '0;
      end else if (p3_vld_ff) begin
         acc_vld_ff[p3_c_ff] <= 1'b1;
      end
   end

   // datapath
   always_comb begin
      diff     = {store_rd_ff[VB-1], store_rd_ff} - {op_value_ff[VB-1], op_value_ff};
      diff_neg = -diff;
      mag      = diff[DW-1] ? diff_neg[VB-1:0] : diff[VB-1:0];
      old_val  = acc_vld_ff[p1_c_ff] ? acc_rd_ff : '0;
      sum      = SW'(p3_old_ff) + SW'(p3_sq_ff);
      sum_sat  = (sum > SW'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];
      take     = (p3_c_ff == '0) || (sum_sat < best_dist_ff);
      nb_dist  = take ? sum_sat : best_dist_ff;
      nb_idx   = take ? p3_c_ff : best_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= issue;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_c_ff    <= c_ff;
      p1_last_ff <= c_last;
      p2_c_ff    <= p1_c_ff;
      p2_last_ff <= p1_last_ff;
      p2_mag_ff  <= mag;
      p2_old_ff  <= old_val;
      p3_c_ff    <= p2_c_ff;
      p3_last_ff <= p2_last_ff;
      p3_sq_ff   <= SQW'(p2_mag_ff) * SQW'(p2_mag_ff);
      p3_old_ff  <= p2_old_ff;
      if (p3_vld_ff) begin
         best_dist_ff <= nb_dist;
         best_idx_ff  <= nb_idx;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (p3_vld_ff && p3_last_ff && op_emit_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (p3_vld_ff && p3_last_ff && op_emit_ff) begin
         rsp_index_ff <= IDX_BITS'(nb_idx);
         rsp_dist_ff  <= nb_dist;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nearest_index = rsp_index_ff;
   assign rsp_min_distance  = rsp_dist_ff;

endmodule

### rtl/nearest_centroid_classifier.sv
`timescale 1ns / 1ps
// Nearest centroid classifier. Coordinate writes (command 0) load the centroid
// store. A query element (command 1) is swept over all centroids in use by one
// shared squared-difference unit, one centroid per cycle; the element at the last
// dimension in use returns the nearest centroid and its squared distance. A
// two-entry queue lets the input side keep accepting while the back end works,
// and the result sits in an output register. No clearing pass after reset.

// nearest_centroid_classifier: top level with configuration registers
// depends on ncc_pkg, ncc_front, ncc_queue, ncc_back

module nearest_centroid_classifier #(
   parameter int MAX_CENTROIDS = 32,
   parameter int MAX_DIMS = 32,
   parameter int VALUE_BITS = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ncc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [ncc_pkg::CFG_BITS-1:0]       csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_command,
   input  logic [ncc_pkg::SLOT_BITS-1:0]      req_centroid_slot,
   input  logic [ncc_pkg::DIM_BITS-1:0]       req_dim_index,
   input  logic signed [VALUE_BITS-1:0]       req_coord_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ncc_pkg::IDX_BITS-1:0]       rsp_nearest_index,
   output logic [ncc_pkg::DIST_BITS-1:0]      rsp_min_distance
);

   import ncc_pkg::*;

   localparam int QW = $bits(op_flags_type) + SLOT_BITS + DIM_BITS + VALUE_BITS;

   logic [CFG_BITS-1:0] centroids_ff;
   logic [CFG_BITS-1:0] dims_ff;
   logic [CFG_BITS-1:0] ncent_last;
   logic [CFG_BITS-1:0] ndims_last;
   logic                q_push;
   logic [QW-1:0]       q_push_data;
   logic                q_full;
   logic                q_pop;
   logic                q_valid;
   logic [QW-1:0]       q_data;

   function automatic logic [CFG_BITS-1:0] count_last(input logic [CFG_BITS-1:0] cfg,
                                                      input int unsigned limit);
      logic [CFG_BITS-1:0] res;
      if (cfg == '0) begin
         res = '0;
      end else if (32'(cfg) > limit) begin
         res = CFG_BITS'(limit - 1);
      end else begin
         res = cfg - 1'b1;
      end
      return res;
   endfunction

   assign csr_ready  = 1'b1;
   assign ncent_last = count_last(centroids_ff, MAX_CENTROIDS);
   assign ndims_last = count_last(dims_ff, MAX_DIMS);

   always_ff @(posedge clock) begin
      if (reset) begin
         centroids_ff <= CFG_BITS'(32);
         dims_ff      <= CFG_BITS'(32);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CENTROIDS_IN_USE: begin
               centroids_ff <= csr_wdata;
            end
            CSR_DIMS_IN_USE: begin
               dims_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   ncc_front #(
      .MAX_CENTROIDS(MAX_CENTROIDS),
      .MAX_DIMS(MAX_DIMS),
      .VALUE_BITS(VALUE_BITS),
      .QW(QW)
   ) u_front (
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_centroid_slot(req_centroid_slot),
      .req_dim_index(req_dim_index),
      .req_coord_value(req_coord_value),
      .ndims_last(ndims_last),
      .q_full(q_full),
      .q_push(q_push),
      .q_data(q_push_data)
   );

   ncc_queue #(
      .WIDTH(QW)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data(q_push_data),
      .full(q_full),
      .pop(q_pop),
      .valid(q_valid),
      .data(q_data)
   );

   ncc_back #(
      .MAX_CENTROIDS(MAX_CENTROIDS),
      .MAX_DIMS(MAX_DIMS),
      .VALUE_BITS(VALUE_BITS),
      .QW(QW)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_data(q_data),
      .q_pop(q_pop),
      .ncent_last(ncent_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_nearest_index(rsp_nearest_index),
      .rsp_min_distance(rsp_min_distance)
   );

endmodule
